/* design/srm_pkg.sv */
// shared types and constants for the schedule rule matcher
package srm_pkg;

  localparam int NUM_RULES = 16;
  localparam int IDX_W     = $clog2(NUM_RULES);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] month_day;
    logic [3:0] month;
    logic [2:0] week_day;
  } time_t;

  typedef struct packed {
    logic [4:0] wild;
    time_t      tm;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

/* design/schedule_rule_matcher_core.sv */
// schedule rule matcher: rule table in ram, one rule checked per cycle on a tick while the output is not stalled
// a write word is taken in idle and the next word can be taken in the following cycle
// a tick scans all NUM_RULES entries through the ram read port, one per cycle
// while the output is not stalled, and in_stall stays high until the final word is issued
// fires are held one deep so the final one can carry last; a quiet tick gives one word
// synchronous active-low reset clears enable bits, matched flags and control state;
// the rule ram holds no reset and needs no clearing pass
module schedule_rule_matcher_core
  import srm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [3:0] in_rule_slot,
  input  logic       in_enable,
  input  logic [4:0] in_any_mask,
  input  logic [5:0] in_minute,
  input  logic [4:0] in_hour,
  input  logic [4:0] in_month_day,
  input  logic [3:0] in_month,
  input  logic [2:0] in_week_day,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_fired,
  output logic [3:0] out_fired_rule,
  output logic       out_last
);

  state_t               state_r, state_nxt;
  logic [NUM_RULES-1:0] en_r, en_nxt;
  logic [NUM_RULES-1:0] flag_r, flag_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  time_t                now_r, now_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fired_r, out_fired_nxt;
  logic [3:0]           out_fired_rule_r, out_fired_rule_nxt;
  logic                 out_last_r, out_last_nxt;

  logic              in_acc, out_free;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  rule_t             ram_wdata, ram_rdata;
  time_t             in_time;
  logic              hit, active, fire, advance;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign in_time.minute    = in_minute;
  assign in_time.hour      = in_hour;
  assign in_time.month_day = in_month_day;
  assign in_time.month     = in_month;
  assign in_time.week_day  = in_week_day;

  assign ram_we         = in_acc && (in_opcode == OP_WRITE);
  assign ram_wdata.wild = in_any_mask;
  assign ram_wdata.tm   = in_time;

  srm_ram #(
    .WIDTH(RULE_W),
    .DEPTH(NUM_RULES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_rule_slot[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rule match against latched time
  always_comb begin
    hit = (ram_rdata.wild[0] || ram_rdata.tm.minute    == now_r.minute)
       && (ram_rdata.wild[1] || ram_rdata.tm.hour      == now_r.hour)
       && (ram_rdata.wild[2] || ram_rdata.tm.month_day == now_r.month_day)
       && (ram_rdata.wild[3] || ram_rdata.tm.month     == now_r.month)
       && (ram_rdata.wild[4] || ram_rdata.tm.week_day  == now_r.week_day);
    active  = en_r[idx_r];
    fire    = active && hit && !flag_r[idx_r];
    advance = !(fire && pend_v_r) || out_free;
  end

  always_comb begin
    state_nxt          = state_r;
    en_nxt             = en_r;
    flag_nxt           = flag_r;
    idx_nxt            = idx_r;
    pend_v_nxt         = pend_v_r;
    pend_idx_nxt       = pend_idx_r;
    now_nxt            = now_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_fired_nxt      = out_fired_r;
    out_fired_rule_nxt = out_fired_rule_r;
    out_last_nxt       = out_last_r;
    ram_re             = 1'b0;
    ram_raddr          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_WRITE) begin
            en_nxt[in_rule_slot[IDX_W-1:0]]   = in_enable;
            flag_nxt[in_rule_slot[IDX_W-1:0]] = 1'b0;
          end else begin
            now_nxt   = in_time;
            idx_nxt   = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (active) begin
            flag_nxt[idx_r] = hit;
          end
          if (fire) begin
            if (pend_v_r) begin
              out_valid_nxt      = 1'b1;
              out_fired_nxt      = 1'b1;
              out_fired_rule_nxt = 4'(pend_idx_r);
              out_last_nxt       = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = idx_r;
          end
          if (idx_r == IDX_W'(NUM_RULES - 1)) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_fired_nxt      = pend_v_r;
          out_fired_rule_nxt = pend_v_r ? 4'(pend_idx_r) : 4'd0;
          out_last_nxt       = 1'b1;
          pend_v_nxt         = 1'b0;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      en_r        <= '0;
      flag_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      flag_r      <= flag_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r            <= idx_nxt;
    pend_idx_r       <= pend_idx_nxt;
    now_r            <= now_nxt;
    out_fired_r      <= out_fired_nxt;
    out_fired_rule_r <= out_fired_rule_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_fired_rule = out_fired_rule_r;
  assign out_last       = out_last_r;

  a_word_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fired_r || out_last_r))
    else $error("result word neither fired nor last");

  a_quiet_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_fired_r) |-> (out_fired_rule_r == 4'd0 && out_last_r))
    else $error("quiet result word malformed");

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("pending fire left after tick finished");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == OP_TICK) |=> (state_r == ST_SCAN && idx_r == '0))
    else $error("tick did not start scan at rule zero");

  a_scan_leaves_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("flush did not emit final word");

endmodule

/* design/srm_ram.sv */
// generic single-port-write ram with registered read
module srm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
